[design/sac_pkg.sv]
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants for the set-associative tag cache
// geometry, policy codes, controller states, way and command structs
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int Sets     = 64;
    localparam int Ways     = 4;
    localparam int SetBits  = (Sets > 1) ? $clog2(Sets) : 1;
    localparam int WayBits  = (Ways > 1) ? $clog2(Ways) : 1;
    localparam int WayOut   = 2;

    // policy codes
    localparam logic [1:0] PolLru  = 2'd0;
    localparam logic [1:0] PolFifo = 2'd1;
    localparam logic [1:0] PolLfu  = 2'd2;

    // register addresses
    localparam logic [2:0] AddrPolicy = 3'd0;
    localparam logic [2:0] AddrOffset = 3'd4;

    // one way of a set as held in the set memory
    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [31:0] tag;
        logic [31:0] acc_stamp;
        logic [31:0] load_stamp;
        logic [31:0] use_count;
    } t_way;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;

endpackage

[design/sac_ctrl.sv]
// ----------------------------------------------------------------------------
// sac_ctrl: access controller
// sequences capture, set lookup/write-back and result hand-off
// ----------------------------------------------------------------------------
module sac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sac_pkg::t_cmd o_cmd
);
    import sac_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.update = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_LOOKUP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_update_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> o_out_valid) else $error("lookup not followed by result");
    a_no_capture_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> !o_cmd.capture) else $error("capture during lookup");
    a_capture_leads_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.update) else $error("capture without lookup");
`endif

endmodule

[design/sac_dp.sv]
// ----------------------------------------------------------------------------
// sac_dp: cache datapath
// set memory, tag compare, victim choice, stamps and event totals
// ----------------------------------------------------------------------------
module sac_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sac_pkg::t_cmd i_cmd,
    input  logic [1:0]    i_policy,
    input  logic [2:0]    i_offset_bits,
    input  logic          i_mode,
    input  logic [31:0]   i_address,
    output logic          o_hit,
    output logic [1:0]    o_way,
    output logic          o_evicted,
    output logic          o_conflict,
    output logic [31:0]   o_totals [6]
);
    import sac_pkg::*;

    localparam logic [31:0] Sat = '1;

    // set memory, one row per set; valid bits in flops so reset is instant
    t_way              mem [Sets][Ways];
    logic [Ways-1:0]   r_valid [Sets];
    t_way              r_row [Ways];
    logic [Ways-1:0]   r_row_valid;

    logic              r_mode;
    logic [31:0]       r_line;
    logic [SetBits-1:0] r_set;
    logic [31:0]       r_clock;
    logic [31:0]       r_tot [6];

    logic [31:0]       n_line;
    logic [SetBits-1:0] n_set;

    assign n_line = i_address >> i_offset_bits;
    if (Sets > 1) begin : g_set
        assign n_set = n_line[SetBits-1:0];
    end else begin : g_noset
        assign n_set = '0;
    end

    // read row at capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_line <= n_line;
            r_set  <= n_set;
            for (int w = 0; w < Ways; w++) begin
                r_row[w] <= mem[n_set][w];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.capture) begin
            r_row_valid <= r_valid[n_set];
        end
    end

    // lookup and victim choice
    logic              hit;
    logic [WayBits-1:0] way;
    logic              found_inv;
    logic [WayBits-1:0] inv_way;
    logic [WayBits-1:0] min_way;
    logic [31:0]       key [Ways];
    logic [31:0]       clk_next;

    assign clk_next = r_clock + 32'd1;

    always_comb begin
        hit = 1'b0;
        way = '0;
        for (int w = Ways - 1; w >= 0; w--) begin
            if (r_row_valid[w] && r_row[w].tag == r_line) begin
                hit = 1'b1;
                way = WayBits'(w);
            end
        end
        found_inv = 1'b0;
        inv_way   = '0;
        for (int w = Ways - 1; w >= 0; w--) begin
            if (!r_row_valid[w]) begin
                found_inv = 1'b1;
                inv_way   = WayBits'(w);
            end
        end
        for (int w = 0; w < Ways; w++) begin
            case (i_policy)
                PolLru:  key[w] = r_row[w].acc_stamp;
                PolFifo: key[w] = r_row[w].load_stamp;
                PolLfu:  key[w] = r_row[w].use_count;
                default: key[w] = '0;
            endcase
        end
        min_way = '0;
        for (int w = 1; w < Ways; w++) begin
            if (key[w] < key[min_way]) min_way = WayBits'(w);
        end
        if (!hit) way = found_inv ? inv_way : min_way;
    end

    logic evict, confl;
    assign evict = !hit && !found_inv;
    assign confl = evict && r_row[way].dirty;

    t_way new_ent;
    always_comb begin
        new_ent = r_row[way];
        if (hit) begin
            new_ent.acc_stamp = clk_next;
            new_ent.use_count = (r_row[way].use_count == Sat) ? Sat
                                : r_row[way].use_count + 32'd1;
        end else begin
            new_ent.valid      = 1'b1;
            new_ent.dirty      = r_mode;
            new_ent.tag        = r_line;
            new_ent.acc_stamp  = clk_next;
            new_ent.load_stamp = clk_next;
            new_ent.use_count  = 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            mem[r_set][way] <= new_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Sets; s++) r_valid[s] <= '0;
        end else if (i_cmd.update) begin
            r_valid[r_set][way] <= 1'b1;
        end
    end

    // totals: accesses, read hits, read misses, write hits, write misses, conflicts
    logic [5:0] inc;
    assign inc = {confl, r_mode & !hit, r_mode & hit, !r_mode & !hit, !r_mode & hit, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            for (int k = 0; k < 6; k++) r_tot[k] <= '0;
            o_hit      <= 1'b0;
            o_way      <= '0;
            o_evicted  <= 1'b0;
            o_conflict <= 1'b0;
        end else if (i_cmd.update) begin
            r_clock <= clk_next;
            for (int k = 0; k < 6; k++) begin
                if (inc[k] && r_tot[k] != Sat) r_tot[k] <= r_tot[k] + 32'd1;
            end
            o_hit      <= hit;
            o_way      <= WayOut'(way);
            o_evicted  <= evict;
            o_conflict <= confl;
        end
    end

    assign o_totals = r_tot;

`ifndef SYNTHESIS
    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evicted |-> !o_hit) else $error("eviction on hit");
    a_conflict_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_conflict |-> o_evicted) else $error("conflict without eviction");
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> r_clock == $past(r_clock) + 32'd1) else $error("clock step");
`endif

endmodule

[design/set_assoc_cache_tag_policy_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_policy_core: tag-only set-associative cache model
// 64 sets by 4 ways, lru / fifo / lfu replacement, running event totals
// ----------------------------------------------------------------------------
// usage
//   slave stream carries one request: tdata = {address, mode}, mode in bit 0
//   master stream returns one result per request with hit, way, eviction,
//   conflict flags and six saturating totals
//   apb port: policy at 0x0, offset_bits at 0x4; write only while idle
// timing
//   the set row is read from the set memory at the accepting edge; it is
//   written back, and the result registered, at the next edge
//   a new request is not taken before the previous result is taken, and the
//   result is valid in the out state, after the read-modify-write of the set
// reset
//   synchronous, active low; all valid bits clear at once, totals and the
//   access clock go to zero, registers to lru and offset two
// stall
//   a result holds until taken and no request is accepted meanwhile; the
//   next request is accepted in the same cycle the result is taken
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_policy_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // mode[0], address[32:1], zero pad
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata    // hit[0], way[2:1], evicted[3],
                                         // conflict[4], access_total[36:5],
                                         // read_hit_total[68:37],
                                         // read_miss_total[100:69],
                                         // write_hit_total[132:101],
                                         // write_miss_total[164:133],
                                         // conflict_total[196:165], zero pad
);
    import sac_pkg::*;

    logic [1:0] r_policy;
    logic [2:0] r_offset_bits;

    // register writes complete in the access phase
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= PolLru;
            r_offset_bits <= 3'd2;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                AddrPolicy: r_policy      <= pwdata[1:0];
                AddrOffset: r_offset_bits <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            AddrPolicy: prdata = {30'd0, r_policy};
            AddrOffset: prdata = {29'd0, r_offset_bits};
            default:    prdata = '0;
        endcase
    end

    t_cmd        cmd;
    logic        hit, evicted, conflict;
    logic [1:0]  way;
    logic [31:0] totals [6];

    sac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    sac_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_policy      (r_policy),
        .i_offset_bits (r_offset_bits),
        .i_mode        (s_axis_tdata[0]),
        .i_address     (s_axis_tdata[32:1]),
        .o_hit         (hit),
        .o_way         (way),
        .o_evicted     (evicted),
        .o_conflict    (conflict),
        .o_totals      (totals)
    );

    assign m_axis_tdata = {3'd0, totals[5], totals[4], totals[3], totals[2],
                           totals[1], totals[0], conflict, evicted, way, hit};

endmodule
